// ===== hw/rtl/rrlpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrlpc_pkg: shared constants for the RC5 remote RGB LED PWM controller
// Level width, channel count, RC5 frame layout, command codes and the
// reset levels of the three color channels.
// ----------------------------------------------------------------------------
package rrlpc_pkg;

	// Width of one color level and of the PWM counter.
	localparam int LEVEL_BITS = 4;
	localparam int LEVEL_MAX_INT = (1 << LEVEL_BITS) - 1;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(LEVEL_MAX_INT);

	// Color channels: red, green, blue.
	localparam int CHANNELS = 3;
	localparam int CHAN_BITS = 2;
	localparam logic [CHAN_BITS-1:0] CHAN_RED = 2'd0;
	localparam logic [CHAN_BITS-1:0] CHAN_BLUE = 2'd2;
	localparam logic [CHAN_BITS-1:0] CHAN_LAST = CHAN_BITS'(CHANNELS - 1);

	// Reset levels, limited to the level range.
	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET_RED =
		LEVEL_BITS'((15 > LEVEL_MAX_INT) ? LEVEL_MAX_INT : 15);
	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET_GREEN = '0;
	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET_BLUE =
		LEVEL_BITS'((7 > LEVEL_MAX_INT) ? LEVEL_MAX_INT : 7);

	// RC5 frame layout.
	localparam int FRAME_BITS = 14;
	localparam int ADDR_BITS = 5;
	localparam int OP_BITS = 6;

	// Configuration register map (word index taken from paddr[2]).
	localparam int PADDR_BITS = 3;
	localparam logic REG_DEVICE_ADDRESS = 1'b0;

	// Item kinds.
	localparam logic KIND_TICK = 1'b0;

	// RC5 command codes.
	localparam logic [OP_BITS-1:0] OP_STANDBY = 6'd12;
	localparam logic [OP_BITS-1:0] OP_MUTE = 6'd13;
	localparam logic [OP_BITS-1:0] OP_VOL_UP = 6'd16;
	localparam logic [OP_BITS-1:0] OP_VOL_DOWN = 6'd17;
	localparam logic [OP_BITS-1:0] OP_CH_UP = 6'd32;
	localparam logic [OP_BITS-1:0] OP_CH_DOWN = 6'd33;

endpackage
`default_nettype wire

// ===== hw/rtl/remote_rgb_led_pwm_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// remote_rgb_led_pwm_controller: RGB LED PWM controller driven by RC5 frames
// Each input word is a PWM tick or a decoded RC5 frame; each produces one
// output word with LED enables, selected channel, power and flash status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command and frame. A command of
//   zero is a PWM tick, one is a received 14-bit RC5 frame. The output channel
//   (out_valid/out_ready) carries one word per input word, in order.
//   The APB port holds device_address at byte address 0; write it only while
//   the block is idle. pready is always high.
// Path: an accepted word is registered in the input stage, then processed and
//   put in the output register, where its result is shown.
// Throughput: one word per cycle. The input stage and the output register
//   both move whenever the output register is empty or being taken, so the
//   block keeps accepting while the receiver takes every word.
// Stall: when out_ready is low, the output register holds its word, the
//   input stage holds one more, and in_ready drops until space frees up.
// Reset: arst_n clears both stages; power is on, red is selected, levels are
//   red full, green off, blue at mid scale, and the PWM counter is zero.
// ----------------------------------------------------------------------------
module remote_rgb_led_pwm_controller (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rrlpc_pkg::PADDR_BITS-1:0]   paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	// Input channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               command,
	input  wire logic [rrlpc_pkg::FRAME_BITS-1:0]   frame,
	// Output channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [rrlpc_pkg::CHANNELS-1:0]          led_drive,
	output logic [rrlpc_pkg::CHAN_BITS-1:0]         selected_channel,
	output logic                                    powered,
	output logic                                    flash
);
	import rrlpc_pkg::*;

	// Configuration register.
	logic [ADDR_BITS-1:0] device_address_q;

	// Controller state.
	logic                  power_on_q;
	logic [CHAN_BITS-1:0]  channel_index_q;
	logic [LEVEL_BITS-1:0] channel_level_q [CHANNELS];
	logic [LEVEL_BITS-1:0] pwm_count_q;
	logic [FRAME_BITS-1:0] last_frame_q;

	// Input stage.
	logic                  valid_s1;
	logic                  command_s1;
	logic [FRAME_BITS-1:0] frame_s1;

	// Output register.
	logic                  out_valid_q;
	logic [CHANNELS-1:0]   led_drive_q;
	logic [CHAN_BITS-1:0]  selected_channel_q;
	logic                  powered_q;
	logic                  flash_q;

	// Handshake control.
	logic advance;
	logic process;
	logic cfg_write;

	// Next-state values from the input stage.
	logic                  power_on_d;
	logic [CHAN_BITS-1:0]  channel_index_d;
	logic                  level_we;
	logic [LEVEL_BITS-1:0] level_d;
	logic [LEVEL_BITS-1:0] pwm_count_d;
	logic [FRAME_BITS-1:0] last_frame_d;
	logic [CHANNELS-1:0]   leds_d;
	logic                  flash_d;

	assign advance   = !out_valid_q || out_ready;
	assign process   = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_write = psel && penable && pwrite && pready;

	// APB port: single register, pready tied high.
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DEVICE_ADDRESS) begin
			prdata = {{(32-ADDR_BITS){1'b0}}, device_address_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= '0;
		end else if (cfg_write && paddr[2] == REG_DEVICE_ADDRESS) begin
			device_address_q <= pwdata[ADDR_BITS-1:0];
		end
	end

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			frame_s1   <= frame;
		end
	end

	// Tick and frame processing for the word in the input stage.
	always_comb begin
		logic                  accept;
		logic [OP_BITS-1:0]    op;
		logic [LEVEL_BITS-1:0] sel_level;
		logic                  sel_ok;

		power_on_d      = power_on_q;
		channel_index_d = channel_index_q;
		level_we        = 1'b0;
		level_d         = '0;
		pwm_count_d     = pwm_count_q;
		last_frame_d    = last_frame_q;
		leds_d          = '0;
		flash_d         = 1'b0;

		op        = frame_s1[OP_BITS-1:0];
		accept    = (frame_s1[13:12] == 2'b11) &&
			(frame_s1[OP_BITS+ADDR_BITS-1:OP_BITS] == device_address_q);
		sel_ok    = (channel_index_q <= CHAN_LAST);
		sel_level = sel_ok ? channel_level_q[channel_index_q] : '0;

		if (command_s1 == KIND_TICK) begin
			// PWM tick: while powered, light each channel whose level exceeds the counter.
			if (power_on_q) begin
				for (int i = 0; i < CHANNELS; i++) begin
					leds_d[i] = (channel_level_q[i] > pwm_count_q);
				end
				pwm_count_d = pwm_count_q + 1'b1;
			end
		end else if (frame_s1 != last_frame_q) begin
			// New frame: store it, then run its command if both start bits are set and its address is ours.
			last_frame_d = frame_s1;
			if (accept) begin
				case (op)
					OP_STANDBY: begin
						power_on_d = !power_on_q;
					end
					OP_MUTE: begin
						flash_d = 1'b1;
					end
					OP_CH_UP: begin
						if (power_on_q) begin
							if (channel_index_q == CHAN_LAST) begin
								channel_index_d = CHAN_RED;
							end else begin
								channel_index_d = channel_index_q + 1'b1;
							end
						end
					end
					OP_CH_DOWN: begin
						if (power_on_q) begin
							if (channel_index_q == CHAN_RED) begin
								channel_index_d = CHAN_BLUE;
							end else begin
								channel_index_d = channel_index_q - 1'b1;
							end
						end
					end
					OP_VOL_UP: begin
						if (power_on_q && sel_ok) begin
							level_we = 1'b1;
							level_d  = (sel_level == LEVEL_MAX) ? sel_level
								: sel_level + 1'b1;
						end
					end
					OP_VOL_DOWN: begin
						if (power_on_q && sel_ok) begin
							level_we = 1'b1;
							level_d  = (sel_level == '0) ? sel_level
								: sel_level - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Controller state update, one word per cycle while the output register can advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_q         <= 1'b1;
			channel_index_q    <= CHAN_RED;
			channel_level_q[0] <= LEVEL_RESET_RED;
			channel_level_q[1] <= LEVEL_RESET_GREEN;
			channel_level_q[2] <= LEVEL_RESET_BLUE;
			pwm_count_q        <= '0;
			last_frame_q       <= '0;
		end else if (process) begin
			power_on_q      <= power_on_d;
			channel_index_q <= channel_index_d;
			pwm_count_q     <= pwm_count_d;
			last_frame_q    <= last_frame_d;
			if (level_we) begin
				channel_level_q[channel_index_q] <= level_d;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			led_drive_q        <= leds_d;
			selected_channel_q <= channel_index_d;
			powered_q          <= power_on_d;
			flash_q            <= flash_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign led_drive        = led_drive_q;
	assign selected_channel = selected_channel_q;
	assign powered          = powered_q;
	assign flash            = flash_q;

endmodule
`default_nettype wire
